FILE: hw/rtl/sha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam logic [7:0]  PadByte    = 8'h80;

  typedef logic [31:0] word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       store_byte;   // write in_byte at the fill position
    logic [7:0] in_byte;
    logic       count_bits;   // add eight to the bit count
    logic       write_len;    // put the bit count in bytes 56..63
    logic       start;        // begin a compression
    logic       reinit;       // chaining words back to IV, count to zero
  } sha_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic done;               // compression finished this cycle
  } sha_stat_t;

  localparam word_t Iv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sha_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sha_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module sha_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sha_pkg::sha_cmd_t cmd_i,
  input  wire logic [5:0]       fill_i,
  input  wire logic [2:0]       rd_idx_i,
  output sha_pkg::sha_stat_t    stat_o,
  output sha_pkg::word_t        hash_word_o
);
  import sha_pkg::*;

  word_t       blk_q [16];
  word_t       h_q [8];
  word_t       v_q [8];
  word_t       w_q [16];
  logic [63:0] bits_q;
  logic [5:0]  rnd_q;
  logic        busy_q;
  logic        fin_q;

  word_t s0, s1, w_new, w_cur, big1, big0, ch, maj, t1, t2;

  // Message schedule: a 16-word window, new word at the end
  always_comb begin
    s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = s1 + w_q[9] + s0 + w_q[0];
    w_cur = w_q[0];
    big1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1    = v_q[7] + big1 + ch + RoundK[rnd_q] + w_cur;
    big0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2    = big0 + maj;
  end

  // Block buffer as 16 big-endian words; bytes written one lane at a time, the length as two whole words
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte) begin
      blk_q[fill_i[5:2]][{~fill_i[1:0], 3'b000} +: 8] <= cmd_i.in_byte;
    end
    if (cmd_i.write_len) begin
      blk_q[14] <= bits_q[63:32];
      blk_q[15] <= bits_q[31:0];
    end
  end

  // Round engine, one round per cycle, then a fold into the chaining words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      rnd_q  <= '0;
      bits_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= Iv[i];
      for (int i = 0; i < 8; i++) v_q[i] <= '0;
      for (int i = 0; i < 16; i++) w_q[i] <= '0;
    end else begin
      fin_q <= 1'b0;
      if (cmd_i.count_bits) bits_q <= bits_q + 64'd8;
      if (cmd_i.reinit) begin
        bits_q <= '0;
        for (int i = 0; i < 8; i++) h_q[i] <= Iv[i];
      end
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
        for (int i = 0; i < 16; i++) w_q[i] <= blk_q[i];
      end else if (busy_q) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= w_new;
        v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
        rnd_q  <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          busy_q <= 1'b0;
        end
      end
      if (fin_q) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (busy_q && rnd_q == 6'd63) fin_q <= 1'b1;
    end
  end

  assign stat_o.done = fin_q;
  assign hash_word_o = h_q[rd_idx_i];

endmodule
`default_nettype wire

FILE: hw/rtl/sha_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sha_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              in_has_i,
  input  wire logic              in_end_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             out_idx_o,
  output sha_pkg::sha_cmd_t      cmd_o,
  output logic [5:0]             fill_o,
  input  wire sha_pkg::sha_stat_t stat_i
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StBlock, StWait, StPad, StLen, StFinal, StEmit
  } state_e;

  state_e      state_q;
  logic [6:0]  fill_q;
  logic        endp_q;   // pad byte still owed
  logic        pad_q;    // padding in progress
  logic        last_q;   // compression running is the last of the message
  logic [2:0]  idx_q;
  logic        acc;
  logic        at_len;

  assign acc         = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit);
  assign out_idx_o   = idx_q;
  assign fill_o      = fill_q[5:0];
  assign at_len      = !endp_q && (fill_q == 7'(LenPos));

  // Command decode
  always_comb begin
    cmd_o = '0;
    cmd_o.in_byte = in_byte_i;
    unique case (state_q)
      StIdle: begin
        if (acc && in_has_i) begin
          cmd_o.store_byte = 1'b1;
          cmd_o.count_bits = 1'b1;
        end else if (acc && in_end_i) begin
          cmd_o.store_byte = 1'b1;
          cmd_o.in_byte    = PadByte;
        end
      end
      StBlock: cmd_o.start = 1'b1;
      StPad: begin
        cmd_o.store_byte = !at_len;
        cmd_o.in_byte    = endp_q ? PadByte : 8'h00;
      end
      StLen:   cmd_o.write_len = 1'b1;
      StFinal: cmd_o.start = 1'b1;
      StEmit:  cmd_o.reinit = out_ready_i && (idx_q == 3'd7);
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      endp_q  <= 1'b0;
      pad_q   <= 1'b0;
      last_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (acc && in_has_i) begin
            fill_q <= fill_q + 7'd1;
            endp_q <= in_end_i;
            pad_q  <= in_end_i;
            if (fill_q == 7'(BlockBytes - 1)) state_q <= StBlock;
            else if (in_end_i) state_q <= StPad;
          end else if (acc && in_end_i) begin
            // pad byte stored directly
            fill_q <= fill_q + 7'd1;
            endp_q <= 1'b0;
            pad_q  <= 1'b1;
            if (fill_q == 7'(BlockBytes - 1)) state_q <= StBlock;
            else state_q <= StPad;
          end
        end
        StBlock: begin
          fill_q  <= '0;
          state_q <= StWait;
        end
        StWait: begin
          if (stat_i.done) begin
            priority if (pad_q) state_q <= StPad;
            else if (last_q) state_q <= StEmit;
            else state_q <= StIdle;
          end
        end
        StPad: begin
          if (at_len) begin
            state_q <= StLen;
          end else begin
            fill_q <= fill_q + 7'd1;
            endp_q <= 1'b0;
            // spill block: compress it, padding goes on after
            if (fill_q == 7'(BlockBytes - 1)) state_q <= StBlock;
          end
        end
        StLen:   state_q <= StFinal;
        StFinal: begin
          fill_q  <= '0;
          pad_q   <= 1'b0;
          last_q  <= 1'b1;
          state_q <= StWait;
        end
        StEmit: begin
          if (out_ready_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              last_q  <= 1'b0;
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sha256_message_hasher.sv
// Channel  Dir  Payload                                   Handshake
// in_req   in   data_byte[8] has_byte end_of_message      valid/ready
// out_req  out  digest_word[32] word_index[3] last_word   valid/ready
// One request per cycle while a block fills; a full block stalls input
// while it is started, run through 64 rounds in one round unit and folded.
// End of message: pad, length and start in the last block (a spill block
// adds pad bytes and a compression of its own), then rounds and fold, then
// eight digest requests. rst_ni is asynchronous, active low; a stalled
// output holds its word.
`timescale 1ns / 1ps
`default_nettype none
module sha256_message_hasher (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sha_in_if.sink    in_req,
  sha_out_if.source out_req
);
  import sha_pkg::*;

  sha_cmd_t  cmd;
  sha_stat_t stat;
  logic [5:0] fill;
  logic [2:0] idx;
  word_t      hw;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_req.valid),
    .in_ready_o (in_req.ready),
    .in_byte_i  (in_req.data_byte),
    .in_has_i   (in_req.has_byte),
    .in_end_i   (in_req.end_of_message),
    .out_valid_o(out_req.valid),
    .out_ready_i(out_req.ready),
    .out_idx_o  (idx),
    .cmd_o      (cmd),
    .fill_o     (fill),
    .stat_i     (stat)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .fill_i     (fill),
    .rd_idx_i   (idx),
    .stat_o     (stat),
    .hash_word_o(hw)
  );

  assign out_req.digest_word = hw;
  assign out_req.word_index  = idx;
  assign out_req.last_word   = (idx == 3'd7);

endmodule
`default_nettype wire

FILE: hw/rtl/sha_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sha_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [2:0]  word_index_i,
  input wire logic        last_word_i,
  input wire logic [31:0] digest_word_i
);
  // never take input while the digest is going out
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i)) else $error("input open during digest");
  // last flag marks index seven
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_word_i == (word_index_i == 3'd7))) else $error("last flag");
  // word index steps by one per request
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !last_word_i) |=> (out_valid_i &&
    word_index_i == $past(word_index_i) + 3'd1)) else $error("index step");
  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(digest_word_i)) else $error("word moved");
endmodule

bind sha256_message_hasher sha_checker u_sha_checker (
  .clk_i, .rst_ni,
  .in_valid_i   (in_req.valid),
  .in_ready_i   (in_req.ready),
  .out_valid_i  (out_req.valid),
  .out_ready_i  (out_req.ready),
  .word_index_i (out_req.word_index),
  .last_word_i  (out_req.last_word),
  .digest_word_i(out_req.digest_word)
);
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import sha_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sha_in_if  in_req ();
  sha_out_if out_req ();

  sha256_message_hasher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_req (in_req.sink),
    .out_req(out_req.source)
  );

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    word_t      digest_word;
    logic [2:0] word_index;
    logic       last_word;
  } digest_req_t;

  // predictor state
  word_t       hash_state [8];
  logic [7:0]  msg_block [64];
  int unsigned block_fill;
  logic [63:0] bit_count;

  digest_req_t digest_queue[$];
  int          mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic word_t ror32(word_t x, int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_init();
    hash_state = Iv;
    foreach (msg_block[i]) msg_block[i] = 8'h00;
    block_fill = 0;
    bit_count  = '0;
  endfunction

  function automatic void compress_msg_block();
    word_t sched [64];
    word_t v [8];
    word_t t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      sched[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
      s1 = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
      sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
    end
    v = hash_state;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + sched[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endfunction

  function automatic void append_byte(logic [7:0] b);
    msg_block[block_fill] = b;
    block_fill++;
    if (block_fill == BlockBytes) begin
      compress_msg_block();
      block_fill = 0;
    end
  endfunction

  // Advance the predictor by one accepted request; queue digest words at end.
  function automatic void predict_request(logic [7:0] b, logic hb, logic eom);
    logic [63:0] len;
    digest_req_t d;
    if (hb) begin
      append_byte(b);
      bit_count += 64'd8;
    end
    if (!eom) return;
    len = bit_count;
    append_byte(PadByte);
    while (block_fill != LenPos) append_byte(8'h00);
    for (int i = 0; i < 8; i++) msg_block[LenPos+i] = len[63-8*i -: 8];
    compress_msg_block();
    for (int i = 0; i < 8; i++) begin
      d.digest_word = hash_state[i];
      d.word_index  = 3'(i);
      d.last_word   = (i == 7);
      digest_queue.push_back(d);
    end
    hash_init();
  endfunction

  // Send one request, with random idle cycles before it.
  task automatic send_request(input logic [7:0] b, input logic hb, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_req.valid <= 1'b1;
    in_req.data_byte <= b;
    in_req.has_byte <= hb;
    in_req.end_of_message <= eom;
    @(posedge clk_i);
    while (!in_req.ready) @(posedge clk_i);
    predict_request(b, hb, eom);
  endtask

  task automatic send_message(input int unsigned nbytes);
    for (int i = 0; i < nbytes; i++) send_request(8'($urandom), 1'b1, 1'b0);
    send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver: random stall, check each accepted digest word.
  always @(posedge clk_i) begin
    digest_req_t w;
    if (out_req.valid && out_req.ready) begin
      if (digest_queue.size() == 0) begin
        report_mismatch("unexpected word", out_req.digest_word, 32'h0);
      end else begin
        w = digest_queue.pop_front();
        if (out_req.digest_word !== w.digest_word)
          report_mismatch("digest_word", out_req.digest_word, w.digest_word);
        if (out_req.word_index !== w.word_index)
          report_mismatch("word_index", 32'(out_req.word_index), 32'(w.word_index));
        if (out_req.last_word !== w.last_word)
          report_mismatch("last_word", 32'(out_req.last_word), 32'(w.last_word));
      end
    end
    if (rst_ni) out_req.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Empty message, end marker with and without a byte, stray empty requests, byte extremes.
  task automatic test_edge_cases();
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h5a, 1'b0, 1'b0);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'haa, 1'b1, 1'b0);
    send_request(8'h55, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h33, 1'b0, 1'b1);
  endtask

  // Padding spills: 0x80 at byte 56 (end on the last byte), and 0x80 at
  // byte 63 (bare end marker after 63 bytes).
  task automatic test_pad_boundaries();
    for (int i = 0; i < 55; i++) send_request(8'($urandom), 1'b1, 1'b0);
    send_request(8'($urandom), 1'b1, 1'b1);
    send_message(63);
  endtask

  // Random short messages, with stray empty requests mixed in.
  task automatic test_random_messages(input int unsigned nreq);
    int unsigned sent = 0;
    int unsigned n;
    while (sent < nreq) begin
      n = $urandom_range(12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(7) == 0) begin
          send_request(8'($urandom), 1'b0, 1'b0);
          sent++;
        end
        send_request(8'($urandom), 1'b1, 1'b0);
        sent++;
      end
      send_request(8'($urandom), 1'($urandom), 1'b1);
      sent++;
    end
  endtask

  task automatic wait_drained();
    while (digest_queue.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    in_req.valid = 1'b0;
    in_req.data_byte = '0;
    in_req.has_byte = 1'b0;
    in_req.end_of_message = 1'b0;
    out_req.ready = 1'b0;
    hash_init();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_cases();
    test_pad_boundaries();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random_messages(10);
    send_idle_pct = 59; recv_stall_pct = 0;  test_random_messages(10);
    send_idle_pct = 0;  recv_stall_pct = 59; test_random_messages(10);
    send_idle_pct = 13; recv_stall_pct = 13; test_random_messages(10);
    in_req.valid <= 1'b0;
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
